[hw/rtl/archive_entry_stream_deframer_core_assert.svh]
// Assertion macros shared by the deframer checker.
`ifndef ARCHIVE_ENTRY_STREAM_DEFRAMER_CORE_ASSERT_SVH
`define ARCHIVE_ENTRY_STREAM_DEFRAMER_CORE_ASSERT_SVH

// Concurrent assertion, off while reset is high.
`define AESD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define AESD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/aesd_pkg.sv]
// Types and constants of the archive entry stream deframer.
`default_nettype none

package aesd_pkg;

   localparam int POSITION_BITS = 40;
   localparam int LENGTH_BITS   = 40;
   localparam int HDR_LEN       = 30;
   localparam int FILL_BITS     = $clog2(HDR_LEN + 1);
   localparam int END_MARGIN    = 90;
   localparam int CMP_BITS      = ((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS) + 1;

   localparam logic [31:0] MAGIC_V2 = 32'h0000_0210;
   localparam logic [31:0] MAGIC_V1 = 32'h0000_0110;
   localparam logic [31:0] MAGIC_V3 = 32'h0000_0310;

   typedef enum logic [1:0] {
      KIND_ENTRY   = 2'd0,
      KIND_CORRUPT = 2'd1,
      KIND_NAME    = 2'd2,
      KIND_CONTENT = 2'd3
   } aesd_kind_type;

   typedef enum logic [4:0] {
      PH_HEADER  = 5'b00001,
      PH_NAME    = 5'b00010,
      PH_CONTENT = 5'b00100,
      PH_RESYNC  = 5'b01000,
      PH_DONE    = 5'b10000
   } aesd_phase_type;

   typedef struct packed {
      aesd_kind_type            kind;
      logic [7:0]               data_byte;
      logic                     last_of_run;
      logic [31:0]              entry_index;
      logic [POSITION_BITS-1:0] header_offset;
      logic [31:0]              file_size;
      logic [15:0]              name_length;
      logic [15:0]              owner_id;
      logic [15:0]              group_id;
      logic [15:0]              mode_bits;
      logic                     recovered;
   } aesd_result_type;

endpackage

`default_nettype wire

[hw/rtl/aesd_req_if.sv]
// Byte input channel of the deframer.
`default_nettype none

interface aesd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;

   modport source (output valid, output byte_value, input ready);
   modport sink   (input valid, input byte_value, output ready);
endinterface

`default_nettype wire

[hw/rtl/aesd_rsp_if.sv]
// Result channel of the deframer.
`default_nettype none

interface aesd_rsp_if import aesd_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [1:0]               kind;
   logic [7:0]               data_byte;
   logic                     last_of_run;
   logic [31:0]              entry_index;
   logic [POSITION_BITS-1:0] header_offset;
   logic [31:0]              file_size;
   logic [15:0]              name_length;
   logic [15:0]              owner_id;
   logic [15:0]              group_id;
   logic [15:0]              mode_bits;
   logic                     recovered;

   modport source (
      output valid, output kind, output data_byte, output last_of_run,
      output entry_index, output header_offset, output file_size,
      output name_length, output owner_id, output group_id, output mode_bits,
      output recovered, input ready
   );
   modport sink (
      input valid, input kind, input data_byte, input last_of_run,
      input entry_index, input header_offset, input file_size,
      input name_length, input owner_id, input group_id, input mode_bits,
      input recovered, output ready
   );
endinterface

`default_nettype wire

[hw/rtl/archive_entry_stream_deframer_core.sv]
// Archive entry stream deframer: header parsing, resync and byte tagging.
//
// Usage:
//  req_chan carries one archive byte per transaction. rsp_chan carries at most
//  one result per byte: an entry record, a corrupt-header event, or a tagged
//  name or content byte with the last byte of each run flagged.
//  csr_write_data is the total stream length; write it while the block is idle.
//  Results are registered, and pass through the skid register on a stall.
//  Throughput: one byte per cycle while the skid register is empty; each byte
//  passes through a single layer of logic (window shift, header compare,
//  32-bit counter update) into the result register.
//  Stall: results sit in a two-entry output stage (result register plus skid
//  register). A stalled receiver fills the skid entry, after which req ready
//  drops until rsp_chan takes a result.
//  Reset: synchronous, active high. It clears the phase, counters, position,
//  stream length and both output entries. With a stream length of zero the
//  first byte puts the block in its finished phase, where it drops all bytes
//  until the next reset.
`default_nettype none

module archive_entry_stream_deframer_core
   import aesd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   aesd_req_if.sink                    req_chan,
   aesd_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_write_enable,
   input  wire logic [LENGTH_BITS-1:0] csr_write_data
);

   // State registers
   aesd_phase_type           phase_ff, phase_in;
   logic [7:0]               window_ff [HDR_LEN];
   logic [7:0]               window_in [HDR_LEN];
   logic [FILL_BITS-1:0]     fill_ff, fill_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [31:0]              remaining_ff, remaining_in;
   logic [31:0]              pending_ff, pending_in;
   logic [31:0]              accepted_ff, accepted_in;
   logic [LENGTH_BITS-1:0]   stream_length_ff;

   // Current entry fields
   logic [31:0]              cur_index_ff, cur_index_in;
   logic [POSITION_BITS-1:0] cur_offset_ff, cur_offset_in;
   logic [31:0]              cur_size_ff, cur_size_in;
   logic [15:0]              cur_name_len_ff, cur_name_len_in;
   logic [15:0]              cur_uid_ff, cur_uid_in;
   logic [15:0]              cur_gid_ff, cur_gid_in;
   logic [15:0]              cur_mode_ff, cur_mode_in;
   logic                     resync_ff, resync_in;

   // Output stage
   logic                     out_valid_ff, out_valid_in;
   aesd_result_type          out_data_ff, out_data_in;
   logic                     skid_valid_ff, skid_valid_in;
   aesd_result_type          skid_data_ff, skid_data_in;

   // Per-byte combinational values
   logic                     accept;
   logic [7:0]               in_byte;
   logic [7:0]               shifted [HDR_LEN];
   logic [POSITION_BITS-1:0] start_pos;
   logic [CMP_BITS-1:0]      room_diff;
   logic                     room_ok;
   logic [31:0]              magic;
   logic                     zero_field;
   logic [31:0]              hdr_size;
   logic [15:0]              hdr_name_len;
   logic [31:0]              remaining_dec;
   logic                     run_last;
   logic                     emit;
   aesd_kind_type            emit_kind;
   logic [7:0]               emit_byte;
   logic                     emit_last;
   aesd_result_type          result;

   assign req_chan.ready = !skid_valid_ff;
   assign accept         = req_chan.valid && !skid_valid_ff;
   assign in_byte        = req_chan.byte_value;

   // Slide the window by one byte; newest byte lands at the top
   always_comb begin
      for (int i = 0; i < HDR_LEN - 1; i++) begin
         shifted[i] = window_ff[i + 1];
      end
      shifted[HDR_LEN - 1] = in_byte;
   end

   // Decode header fields from the shifted window
   assign magic        = {shifted[3], shifted[2], shifted[1], shifted[0]};
   assign zero_field   = ({shifted[4], shifted[5]} == 16'h0000);
   assign hdr_size     = {shifted[6], shifted[7], shifted[8], shifted[9]};
   assign hdr_name_len = {shifted[22], shifted[23]};

   assign start_pos = pos_ff - POSITION_BITS'(HDR_LEN - 1);
   assign room_diff = CMP_BITS'(stream_length_ff) - CMP_BITS'(pos_ff);
   assign room_ok   = !room_diff[CMP_BITS-1]
                      && (room_diff[CMP_BITS-2:0] > (CMP_BITS-1)'(END_MARGIN));

   assign remaining_dec = (remaining_ff != 32'd0) ? (remaining_ff - 32'd1) : remaining_ff;
   assign run_last      = (remaining_dec == 32'd0);

   // Advance the phase machine for one byte
   always_comb begin
      phase_in        = phase_ff;
      window_in       = window_ff;
      fill_in         = fill_ff;
      pos_in          = pos_ff;
      remaining_in    = remaining_ff;
      pending_in      = pending_ff;
      accepted_in     = accepted_ff;
      cur_index_in    = cur_index_ff;
      cur_offset_in   = cur_offset_ff;
      cur_size_in     = cur_size_ff;
      cur_name_len_in = cur_name_len_ff;
      cur_uid_in      = cur_uid_ff;
      cur_gid_in      = cur_gid_ff;
      cur_mode_in     = cur_mode_ff;
      resync_in       = resync_ff;
      emit            = 1'b0;
      emit_kind       = KIND_ENTRY;
      emit_byte       = 8'h00;
      emit_last       = 1'b0;

      if (accept) begin
         pos_in = pos_ff + POSITION_BITS'(1);
         unique case (phase_ff)
            PH_HEADER: begin
               if ((fill_ff == '0) && !room_ok) begin
                  phase_in = PH_DONE;
               end else begin
                  window_in = shifted;
                  if (fill_ff == FILL_BITS'(HDR_LEN - 1)) begin
                     fill_in         = '0;
                     emit            = 1'b1;
                     cur_index_in    = accepted_ff;
                     cur_offset_in   = start_pos;
                     if (((magic == MAGIC_V2) || (magic == MAGIC_V1) || (magic == MAGIC_V3))
                         && zero_field) begin
                        emit_kind = KIND_ENTRY;
                     end else begin
                        emit_kind       = KIND_CORRUPT;
                        cur_size_in     = 32'd0;
                        cur_name_len_in = 16'd0;
                        cur_uid_in      = 16'd0;
                        cur_gid_in      = 16'd0;
                        cur_mode_in     = 16'd0;
                        resync_in       = 1'b0;
                        phase_in        = PH_RESYNC;
                     end
                  end else begin
                     fill_in = fill_ff + FILL_BITS'(1);
                  end
               end
            end
            PH_RESYNC: begin
               window_in = shifted;
               if (fill_ff != FILL_BITS'(HDR_LEN)) begin
                  fill_in = fill_ff + FILL_BITS'(1);
               end
               if ((fill_ff >= FILL_BITS'(HDR_LEN - 1))
                   && ((magic == MAGIC_V2) || (magic == MAGIC_V1))
                   && zero_field && (hdr_name_len != 16'd0)) begin
                  fill_in       = '0;
                  emit          = 1'b1;
                  emit_kind     = KIND_ENTRY;
                  cur_index_in  = accepted_ff;
                  cur_offset_in = start_pos;
               end
            end
            PH_NAME: begin
               remaining_in = remaining_dec;
               emit         = 1'b1;
               emit_kind    = KIND_NAME;
               emit_byte    = in_byte;
               emit_last    = run_last;
               if (run_last) begin
                  if (pending_ff != 32'd0) begin
                     remaining_in = pending_ff;
                     phase_in     = PH_CONTENT;
                  end else begin
                     fill_in  = '0;
                     phase_in = PH_HEADER;
                  end
               end
            end
            PH_CONTENT: begin
               remaining_in = remaining_dec;
               emit         = 1'b1;
               emit_kind    = KIND_CONTENT;
               emit_byte    = in_byte;
               emit_last    = run_last;
               if (run_last) begin
                  fill_in  = '0;
                  phase_in = PH_HEADER;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase

         // Take a good header: latch fields and pick the next run
         if (emit && (emit_kind == KIND_ENTRY)) begin
            cur_size_in     = hdr_size;
            cur_name_len_in = hdr_name_len;
            cur_uid_in      = {shifted[24], shifted[25]};
            cur_gid_in      = {shifted[26], shifted[27]};
            cur_mode_in     = {shifted[28], shifted[29]};
            resync_in       = (phase_ff == PH_RESYNC);
            accepted_in     = accepted_ff + 32'd1;
            pending_in      = hdr_size;
            if (hdr_name_len != 16'd0) begin
               remaining_in = 32'(hdr_name_len);
               phase_in     = PH_NAME;
            end else if (hdr_size != 32'd0) begin
               remaining_in = hdr_size;
               phase_in     = PH_CONTENT;
            end else begin
               phase_in = PH_HEADER;
            end
         end
      end
   end

   // Build the result from the updated entry fields
   always_comb begin
      result.kind          = emit_kind;
      result.data_byte     = emit_byte;
      result.last_of_run   = emit_last;
      result.entry_index   = cur_index_in;
      result.header_offset = cur_offset_in;
      result.file_size     = cur_size_in;
      result.name_length   = cur_name_len_in;
      result.owner_id      = cur_uid_in;
      result.group_id      = cur_gid_in;
      result.mode_bits     = cur_mode_in;
      result.recovered     = resync_in;
   end

   // Steer results into the result register or the skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_chan.ready) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && emit) begin
         if (!out_valid_ff || rsp_chan.ready) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HEADER;
         fill_ff          <= '0;
         pos_ff           <= '0;
         remaining_ff     <= '0;
         pending_ff       <= '0;
         accepted_ff      <= '0;
         stream_length_ff <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         fill_ff       <= fill_in;
         pos_ff        <= pos_in;
         remaining_ff  <= remaining_in;
         pending_ff    <= pending_in;
         accepted_ff   <= accepted_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_write_enable) begin
            stream_length_ff <= csr_write_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      window_ff       <= window_in;
      cur_index_ff    <= cur_index_in;
      cur_offset_ff   <= cur_offset_in;
      cur_size_ff     <= cur_size_in;
      cur_name_len_ff <= cur_name_len_in;
      cur_uid_ff      <= cur_uid_in;
      cur_gid_ff      <= cur_gid_in;
      cur_mode_ff     <= cur_mode_in;
      resync_ff       <= resync_in;
      out_data_ff     <= out_data_in;
      skid_data_ff    <= skid_data_in;
   end

   // Drive the result channel
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_data_ff.kind;
   assign rsp_chan.data_byte     = out_data_ff.data_byte;
   assign rsp_chan.last_of_run   = out_data_ff.last_of_run;
   assign rsp_chan.entry_index   = out_data_ff.entry_index;
   assign rsp_chan.header_offset = out_data_ff.header_offset;
   assign rsp_chan.file_size     = out_data_ff.file_size;
   assign rsp_chan.name_length   = out_data_ff.name_length;
   assign rsp_chan.owner_id      = out_data_ff.owner_id;
   assign rsp_chan.group_id      = out_data_ff.group_id;
   assign rsp_chan.mode_bits     = out_data_ff.mode_bits;
   assign rsp_chan.recovered     = out_data_ff.recovered;

endmodule

`default_nettype wire

[hw/rtl/aesd_checker.sv]
// Port-level checker for the deframer and its bind to the top level.
`default_nettype none

`include "archive_entry_stream_deframer_core_assert.svh"

module aesd_checker
   import aesd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [7:0]  rsp_data_byte,
   input wire logic        rsp_last_of_run,
   input wire logic [31:0] rsp_entry_index,
   input wire logic [31:0] rsp_file_size,
   input wire logic [15:0] rsp_name_length,
   input wire logic        rsp_recovered
);

   // Hold a stalled result transaction
   `AESD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte) && $stable(rsp_entry_index), "stalled result changed")

   // Entry and corrupt records carry no byte and no run end
   `AESD_ASSERT(a_record_no_byte, clock, reset, rsp_valid && (rsp_kind == KIND_ENTRY || rsp_kind == KIND_CORRUPT) |-> rsp_data_byte == 8'h00 && !rsp_last_of_run, "record carries byte data")

   // Corrupt events clear the header fields
   `AESD_ASSERT(a_corrupt_clear, clock, reset, rsp_valid && rsp_kind == KIND_CORRUPT |-> rsp_file_size == 32'd0 && rsp_name_length == 16'd0 && !rsp_recovered, "corrupt event with header fields")

   // Drop any pending result on reset
   `AESD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind archive_entry_stream_deframer_core aesd_checker u_aesd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_data_byte   (rsp_chan.data_byte),
   .rsp_last_of_run (rsp_chan.last_of_run),
   .rsp_entry_index (rsp_chan.entry_index),
   .rsp_file_size   (rsp_chan.file_size),
   .rsp_name_length (rsp_chan.name_length),
   .rsp_recovered   (rsp_chan.recovered)
);

`default_nettype wire
